// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the window predictor.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/mlpwp_pkg.sv =====
// Types, constants and the rounding function of the window predictor.
// No dependencies; used by mlpwp_mac, mlp_window_predictor and the testbench.
package mlpwp_pkg;

	localparam int DATA_W   = 16;
	localparam int ACC_W    = 40;
	localparam int FRAC_W   = 12;
	localparam int STORE_AW = 10;
	localparam int PROD_W   = 2 * DATA_W;

	localparam logic signed [DATA_W-1:0] BIAS_SCALE = 16'sh1000;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD_HID,
		OP_MAC_HID,
		OP_LOAD_OUT,
		OP_MAC_OUT,
		OP_FIN_HID,
		OP_FIN_OUT
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B2,
		ST_B1,
		ST_MAC1,
		ST_W2,
		ST_FIN,
		ST_GAP,
		ST_W2_LAST,
		ST_OFIN
	} state_t;

	typedef struct packed {
		logic                     fin_out;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] hidden;
	} mac_res_t;

	// Rounds a Q.24 sum half up to Q.12 and saturates it to 16 bits.
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W:0]              s;
		logic [ACC_W-FRAC_W:0]       r;
		logic [ACC_W-FRAC_W-DATA_W+1:0] hi;
		s  = {acc[ACC_W-1], acc} + {{(ACC_W+1-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
		r  = s[ACC_W:FRAC_W];
		hi = r[ACC_W-FRAC_W:DATA_W-1];
		if ((&hi) || !(|hi)) begin
			round_sat = r[DATA_W-1:0];
		end else if (r[ACC_W-FRAC_W]) begin
			round_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== hdl/mlpwp_mac.sv =====
// Shared multiply-accumulate unit: one registered multiplier feeding the
// hidden and output accumulators. Depends on mlpwp_pkg.
module mlpwp_mac import mlpwp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  op_t                      op_s1,
	input  logic signed [DATA_W-1:0] a_s1,
	input  logic signed [DATA_W-1:0] w_s1,
	output mac_res_t                 res
);

	op_t                      op_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  oacc_q;
	logic signed [DATA_W-1:0] h_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  sum;
	logic signed [DATA_W-1:0] hid_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= OP_NOP;
		end else begin
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * w_s1;
	end

	always_comb begin
		prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		sum      = ((op_s2 == OP_MAC_OUT) ? oacc_q : acc_q) + prod_ext;
		hid_rnd  = round_sat(acc_q);
	end

	always_ff @(posedge clk) begin
		case (op_s2)
			OP_LOAD_HID: acc_q  <= prod_ext;
			OP_MAC_HID:  acc_q  <= sum;
			OP_LOAD_OUT: oacc_q <= prod_ext;
			OP_MAC_OUT:  oacc_q <= sum;
			OP_FIN_HID:  h_q    <= hid_rnd[DATA_W-1] ? '0 : hid_rnd;
			default: begin
			end
		endcase
	end

	always_comb begin
		res.fin_out = (op_s2 == OP_FIN_OUT);
		res.value   = round_sat(oacc_q);
		res.hidden  = h_q;
	end

endmodule

// ===== hdl/mlp_window_predictor.sv =====
// Next-sample predictor with a WINDOW_LEN-HIDDEN_UNITS-1 ReLU network.
// Depends on mlpwp_pkg, mlpwp_mac and assert_macros.svh.
//
// A transaction with func low writes one Q3.12 word into the 1024-word weight
// store (W1 input-major at 0, then b1, W2 and b2). A transaction with func
// high shifts a sample into the window; once the window is full it starts an
// inference, and the block stalls its input until the sequencer has issued
// every step. One weight word is read per cycle from the store into one
// shared multiplier, so an inference issues HIDDEN_UNITS*(WINDOW_LEN+3)+3
// steps. The input stall drops in the cycle after the last step, and the
// prediction becomes valid once that step has passed op_s1, op_s2 and the
// output register. The prediction sits in an output register, so the next
// transaction is accepted while it waits to be taken; a later inference holds
// at its last step until the register is free.
`include "assert_macros.svh"

module mlp_window_predictor import mlpwp_pkg::*; #(
	parameter int WINDOW_LEN   = 10,
	parameter int HIDDEN_UNITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [STORE_AW-1:0]        weight_index,
	input  logic signed [DATA_W-1:0]   weight_value,
	input  logic signed [DATA_W-1:0]   sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DATA_W-1:0]   prediction
);

	localparam int KW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int JW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int FW = $clog2(WINDOW_LEN + 1);
	localparam logic [STORE_AW-1:0] B1_BASE_A = STORE_AW'(WINDOW_LEN * HIDDEN_UNITS);
	localparam logic [STORE_AW-1:0] W2_BASE_A =
		STORE_AW'(WINDOW_LEN * HIDDEN_UNITS + HIDDEN_UNITS);
	localparam logic [STORE_AW-1:0] B2_A =
		STORE_AW'(WINDOW_LEN * HIDDEN_UNITS + 2 * HIDDEN_UNITS);
	localparam logic [STORE_AW-1:0] H_STEP = STORE_AW'(HIDDEN_UNITS);
	localparam logic [KW-1:0] K_LAST = KW'(WINDOW_LEN - 1);
	localparam logic [JW-1:0] J_LAST = JW'(HIDDEN_UNITS - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LEN);

	logic signed [DATA_W-1:0] weight_mem_q [1 << STORE_AW];
	logic signed [DATA_W-1:0] win_q [WINDOW_LEN];
	logic [FW-1:0]            fill_q;
	logic [FW-1:0]            fill_next;

	state_t                   state_q, state_d;
	logic [JW-1:0]            j_q, j_d;
	logic [KW-1:0]            k_q, k_d;
	logic [STORE_AW-1:0]      w1a_q, w1a_d;
	op_t                      op_s0;
	logic [STORE_AW-1:0]      addr_s0;

	op_t                      op_s1;
	logic [KW-1:0]            k_s1;
	logic signed [DATA_W-1:0] rd_s1;
	logic signed [DATA_W-1:0] a_s1;
	mac_res_t                 mac_res;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] prediction_q;
	logic                     in_acc;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign fill_next  = (fill_q == FILL_FULL) ? fill_q : fill_q + FW'(1);
	assign out_valid  = out_valid_q;
	assign prediction = prediction_q;

	always_ff @(posedge clk) begin
		if (in_acc && !func) begin
			weight_mem_q[weight_index] <= weight_value;
		end
		rd_s1 <= weight_mem_q[addr_s0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			fill_q <= '0;
		end else if (in_acc && func) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_LEN-1] <= sample;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			w1a_q   <= '0;
			op_s1   <= OP_NOP;
			k_s1    <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			k_q     <= k_d;
			w1a_q   <= w1a_d;
			op_s1   <= op_s0;
			k_s1    <= k_q;
		end
	end

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		k_d     = k_q;
		w1a_d   = w1a_q;
		op_s0   = OP_NOP;
		addr_s0 = w1a_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && func && fill_next == FILL_FULL) begin
					state_d = ST_B2;
				end
			end
			ST_B2: begin
				op_s0   = OP_LOAD_OUT;
				addr_s0 = B2_A;
				j_d     = '0;
				state_d = ST_B1;
			end
			ST_B1: begin
				op_s0   = OP_LOAD_HID;
				addr_s0 = B1_BASE_A + STORE_AW'(j_q);
				w1a_d   = STORE_AW'(j_q);
				k_d     = '0;
				state_d = ST_MAC1;
			end
			ST_MAC1: begin
				op_s0   = OP_MAC_HID;
				addr_s0 = w1a_q;
				w1a_d   = w1a_q + H_STEP;
				k_d     = k_q + KW'(1);
				if (k_q == K_LAST) begin
					state_d = (j_q == '0) ? ST_FIN : ST_W2;
				end
			end
			ST_W2: begin
				op_s0   = OP_MAC_OUT;
				addr_s0 = W2_BASE_A + STORE_AW'(j_q) - STORE_AW'(1);
				state_d = ST_FIN;
			end
			ST_FIN: begin
				op_s0 = OP_FIN_HID;
				if (j_q == J_LAST) begin
					state_d = ST_GAP;
				end else begin
					j_d     = j_q + JW'(1);
					state_d = ST_B1;
				end
			end
			ST_GAP: begin
				state_d = ST_W2_LAST;
			end
			ST_W2_LAST: begin
				op_s0   = OP_MAC_OUT;
				addr_s0 = W2_BASE_A + STORE_AW'(j_q);
				state_d = ST_OFIN;
			end
			ST_OFIN: begin
				if (!out_valid_q) begin
					op_s0   = OP_FIN_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		case (op_s1)
			OP_MAC_HID: a_s1 = win_q[k_s1];
			OP_MAC_OUT: a_s1 = mac_res.hidden;
			default:    a_s1 = BIAS_SCALE;
		endcase
	end

	mlpwp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_s1  (op_s1),
		.a_s1   (a_s1),
		.w_s1   (rd_s1),
		.res    (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mac_res.fin_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_res.fin_out) begin
			prediction_q <= mac_res.value;
		end
	end

	`ASSERT_IMPLIES(a_no_result_overwrite, clk, arst_n, mac_res.fin_out, !out_valid_q)
	`ASSERT_IMPLIES(a_busy_needs_full_window, clk, arst_n, state_q != ST_IDLE, fill_q == FILL_FULL)
	`ASSERT_NEXT(a_full_sample_starts, clk, arst_n, in_acc && func && fill_next == FILL_FULL, state_q == ST_B2)

endmodule

// ===== tb/tb_mlp_window_predictor.sv =====
// Self-checking testbench for mlp_window_predictor, the 10-64-1 ReLU series predictor.
// Depends on mlpwp_pkg and the RTL under hdl; it predicts each output with its own
// fixed-point model and checks it when the prediction is taken from the output.
module tb_mlp_window_predictor;
	timeunit 1ns;
	timeprecision 1ps;
	import mlpwp_pkg::*;

	localparam int WIN_LEN       = 10;
	localparam int HID_N         = 64;
	localparam int B1_BASE       = WIN_LEN * HID_N;
	localparam int W2_BASE       = B1_BASE + HID_N;
	localparam int B2_ADDR       = W2_BASE + HID_N;
	localparam int LAYOUT_WORDS  = B2_ADDR + 1;
	localparam int STORE_WORDS   = 1 << STORE_AW;
	localparam int RANDOM_ITEMS  = 200;
	localparam int DRAIN_CYCLES  = 1000;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_PUSH   = 1'b1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     func = FUNC_WRITE;
	logic [STORE_AW-1:0]      weight_index = '0;
	logic signed [DATA_W-1:0] weight_value = '0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] prediction;

	logic signed [DATA_W-1:0] weight_img [STORE_WORDS];
	logic signed [DATA_W-1:0] window_q [WIN_LEN];
	int                       samples_seen = 0;
	logic signed [DATA_W-1:0] pending_predictions [$];
	logic signed [DATA_W-1:0] expected_pred;
	int                       error_count = 0;
	int                       burst_left = 0;
	int                       stall_run = 0;
	int                       stall_pct = 0;
	int                       cycle_count = 0;

	mlp_window_predictor #(
		.WINDOW_LEN  (WIN_LEN),
		.HIDDEN_UNITS(HID_N)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.weight_index(weight_index),
		.weight_value(weight_value),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prediction  (prediction)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_mlp_window_predictor: FAIL");
		$finish;
	end

	function automatic logic signed [DATA_W-1:0] narrow_q12(input logic signed [ACC_W-1:0] acc);
		longint r;
		r = (longint'(acc) + 64'sd2048) >>> FRAC_W;
		if (r > 32767) begin
			return 16'sh7FFF;
		end
		if (r < -32768) begin
			return 16'sh8000;
		end
		return DATA_W'(r);
	endfunction

	function automatic logic signed [DATA_W-1:0] forecast();
		logic signed [ACC_W-1:0]  hid_acc;
		logic signed [ACC_W-1:0]  out_acc;
		logic signed [DATA_W-1:0] h;
		out_acc = ACC_W'(weight_img[B2_ADDR]);
		out_acc = out_acc <<< FRAC_W;
		for (int j = 0; j < HID_N; j++) begin
			hid_acc = ACC_W'(weight_img[B1_BASE + j]);
			hid_acc = hid_acc <<< FRAC_W;
			for (int k = 0; k < WIN_LEN; k++) begin
				hid_acc = hid_acc + window_q[k] * weight_img[k * HID_N + j];
			end
			h = narrow_q12(hid_acc);
			if (h < 0) begin
				h = '0;
			end
			out_acc = out_acc + h * weight_img[W2_BASE + j];
		end
		return narrow_q12(out_acc);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_q12(input int mag);
		int v;
		v = int'($urandom_range(0, 2 * mag)) - mag;
		if (v > 32767) begin
			v = 32767;
		end
		return DATA_W'(v);
	endfunction

	// Each call starts and ends at a rising edge; the transaction is folded into the
	// prediction state once the input stall is seen low after it is driven.
	task automatic issue_txn(input logic cmd, input logic [STORE_AW-1:0] idx,
			input logic signed [DATA_W-1:0] wv, input logic signed [DATA_W-1:0] smp);
		int gap;
		int k;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		func         <= cmd;
		weight_index <= idx;
		weight_value <= wv;
		sample       <= smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		if (cmd == FUNC_WRITE) begin
			weight_img[idx] = wv;
		end else begin
			for (k = 0; k < WIN_LEN - 1; k++) begin
				window_q[k] = window_q[k + 1];
			end
			window_q[WIN_LEN - 1] = smp;
			if (samples_seen < WIN_LEN) begin
				samples_seen++;
			end
			if (samples_seen == WIN_LEN) begin
				pending_predictions.insert(pending_predictions.size(), forecast());
			end
		end
	endtask

	task automatic write_word(input int addr, input logic signed [DATA_W-1:0] val);
		issue_txn(FUNC_WRITE, STORE_AW'(addr), val, DATA_W'($urandom));
	endtask

	task automatic push_sample(input logic signed [DATA_W-1:0] val);
		issue_txn(FUNC_PUSH, STORE_AW'($urandom), DATA_W'($urandom), val);
	endtask

	task automatic load_image(input int mag);
		for (int a = 0; a < LAYOUT_WORDS; a++) begin
			write_word(a, rand_q12(mag));
		end
	endtask

	task automatic test_window_fill();
		push_sample(16'sh8000);
		push_sample(16'sh7FFF);
		push_sample(16'sh0000);
		push_sample(16'sh0001);
		push_sample(16'shFFFF);
		push_sample(16'sh5555);
		push_sample(16'shAAAA);
		push_sample(DATA_W'($urandom));
		push_sample(DATA_W'($urandom));
	endtask

	task automatic test_output_bias();
		write_word(B2_ADDR, 16'sh7FFF);
		push_sample(DATA_W'($urandom));
		write_word(B2_ADDR, 16'sh8000);
		push_sample(DATA_W'($urandom));
		write_word(B2_ADDR, 16'sh0000);
	endtask

	task automatic test_relu_clamp();
		write_word(W2_BASE, 16'sh1000);
		write_word(B1_BASE, 16'shF000);
		push_sample(DATA_W'($urandom));
		write_word(B1_BASE, 16'sh1000);
		push_sample(DATA_W'($urandom));
	endtask

	task automatic test_rounding();
		write_word(B1_BASE, 16'sh0001);
		write_word(W2_BASE, 16'sh0800);
		push_sample(DATA_W'($urandom));
		write_word(W2_BASE, 16'shF800);
		push_sample(DATA_W'($urandom));
		write_word(W2_BASE, 16'shF7FF);
		push_sample(DATA_W'($urandom));
	endtask

	task automatic test_saturation();
		write_word(B1_BASE, 16'sh0000);
		write_word((WIN_LEN - 1) * HID_N, 16'sh7FFF);
		write_word(W2_BASE, 16'sh7FFF);
		push_sample(16'sh7FFF);
		write_word(W2_BASE, 16'sh8000);
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		write_word(STORE_WORDS - 1, 16'sh8000);
		write_word(0, 16'sh7FFF);
	endtask

	task automatic test_random_traffic();
		int n;
		int roll;
		int mag;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			mag = $urandom_range(0, 9);
			mag = (mag < 7) ? 1024 : (mag < 9) ? 8192 : 32768;
			if (roll < 33) begin
				write_word(int'($urandom_range(0, LAYOUT_WORDS - 1)), rand_q12(mag));
			end else if (roll < 40) begin
				write_word(int'($urandom_range(LAYOUT_WORDS, STORE_WORDS - 1)),
					rand_q12(32768));
			end else if (roll < 85) begin
				push_sample(rand_q12(8192));
			end else if (roll < 94) begin
				push_sample(DATA_W'($urandom));
			end else begin
				case ($urandom_range(0, 2))
					0: push_sample(16'sh8000);
					1: push_sample(16'sh7FFF);
					default: push_sample(16'sh0000);
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(50, 400);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 70;
				default: stall_pct = 95;
			endcase
		end
		stall_run--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_predictions.size() == 0) begin
				$error("prediction: none expected, actual %0d", prediction);
				error_count++;
			end else begin
				expected_pred = pending_predictions.pop_front();
				if (prediction !== expected_pred) begin
					$error("prediction: expected %0d, actual %0d", expected_pred, prediction);
					error_count++;
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < WIN_LEN; k++) begin
			window_q[k] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_fill();
		load_image(0);
		test_output_bias();
		test_relu_clamp();
		test_rounding();
		test_saturation();
		test_random_traffic();
		in_valid <= 1'b0;
		while (pending_predictions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_predictions.size() == 0) begin
			$display("tb_mlp_window_predictor: PASS");
		end else begin
			$display("tb_mlp_window_predictor: FAIL");
		end
		$finish;
	end

endmodule
